FILE: hdl/dfr_pkg.sv
// Shared types and constants for the sync-word, length-prefixed deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package dfr_pkg;

	localparam int SYNC_BYTES   = 4;
	localparam int HEADER_BYTES = 8;
	localparam int QUEUE_DEPTH  = 4;

	localparam int SYNC_IDX_W = $clog2(SYNC_BYTES);
	localparam int HDR_IDX_W  = $clog2(HEADER_BYTES);
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SYNC_IDX_W-1:0] SYNC_LAST_IDX = SYNC_IDX_W'(SYNC_BYTES - 1);
	localparam logic [HDR_IDX_W-1:0]  HDR_LAST_IDX  = HDR_IDX_W'(HEADER_BYTES - 1);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} dfr_phase_t;

	// One payload word on its way to the output.
	typedef struct packed {
		logic        last;
		logic [31:0] len;
		logic [31:0] id;
		logic [7:0]  data;
	} dfr_word_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} dfr_qstat_t;

endpackage

`default_nettype wire

FILE: hdl/magic_sync_length_prefixed_deframer.sv
// Sync-word, length-prefixed deframer: top level.
// Depends on dfr_pkg, dfr_front, dfr_queue and dfr_back.
//
// Usage:
//   s_* : received stream, one byte per word in s_tdata.
//   m_* : payload stream, one word per payload byte, tagged with the message
//         id and length; m_tlast marks the final byte of a message.
//   cfg_*: writes the 32-bit sync word (first byte on the wire in bits 7:0).
//         cfg_ready is always high; write only while the block is idle.
// The front hunts the sync word, captures the 8-byte header (length then id,
// little-endian) and sends payload bytes into a 4-word queue; the back moves
// them into the output register.
// Throughput: one byte per cycle while the queue has room (s_tready drops
// when it is full), set by the front state register.
// Path: a payload byte is written into the queue, then moved into the output
// register, which drives m_tdata, once that register is free.
// Reset: hunting, sync word zero, queue and output empty.
// Stall: a stalled receiver holds the output word; the queue takes up to four
// more words, then s_tready drops until space frees.
`default_nettype none

module magic_sync_length_prefixed_deframer
	import dfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [7:0] payload_byte, [39:8] message_id,
	                                    // [71:40] payload_length
	output logic             m_tlast,   // is_last
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data   // sync_word
);

	dfr_qstat_t qstat;
	logic       push;
	logic       pop;
	dfr_word_t  push_word;
	dfr_word_t  head_word;
	dfr_word_t  out_word;

	assign cfg_ready = 1'b1;

	dfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	dfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.qstat     (qstat)
	);

	dfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_word (head_word),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	assign m_tdata = {out_word.len, out_word.id, out_word.data};
	assign m_tlast = out_word.last;

endmodule

`default_nettype wire

FILE: hdl/dfr_front.sv
// Front part: takes received bytes, hunts the sync word, collects the header
// and pushes tagged payload words into the queue. Uses dfr_pkg.
`default_nettype none

module dfr_front
	import dfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire dfr_qstat_t  qstat,
	output logic             push,
	output dfr_word_t        push_word
);

	dfr_phase_t             phase_q, phase_d;
	logic [SYNC_IDX_W-1:0]  matched_q, matched_d;
	logic [HDR_IDX_W-1:0]   hdr_idx_q, hdr_idx_d;
	logic [31:0]            len_q, len_d;
	logic [31:0]            id_q, id_d;
	logic [31:0]            cnt_q, cnt_d;
	logic [31:0]            sync_q;
	logic                   take;
	logic                   sync_hit;
	logic [32:0]            cnt_inc;
	logic                   is_last;

	assign in_ready = !qstat.full;
	assign take     = in_valid && in_ready;
	assign sync_hit = (in_byte == sync_q[8*matched_q +: 8]);
	assign cnt_inc  = {1'b0, cnt_q} + 33'd1;
	assign is_last  = cnt_inc >= {1'b0, len_q};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					if (hdr_idx_q == HDR_LAST_IDX)
						phase_d = (len_q == 32'd0) ? PH_HUNT : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (is_last)
						phase_d = PH_HUNT;
				end
				default: begin
					phase_d = (sync_hit && matched_q == SYNC_LAST_IDX) ? PH_HEADER : PH_HUNT;
				end
			endcase
		end
	end

	// counters and header capture
	always_comb begin
		matched_d = matched_q;
		hdr_idx_d = hdr_idx_q;
		len_d     = len_q;
		id_d      = id_q;
		cnt_d     = cnt_q;
		if (take) begin
			case (phase_q)
				PH_HEADER: begin
					if (!hdr_idx_q[HDR_IDX_W-1])
						len_d[8*hdr_idx_q[HDR_IDX_W-2:0] +: 8] = in_byte;
					else
						id_d[8*hdr_idx_q[HDR_IDX_W-2:0] +: 8] = in_byte;
					hdr_idx_d = hdr_idx_q + 1'b1;
					cnt_d     = 32'd0;
					matched_d = '0;
				end
				PH_PAYLOAD: begin
					cnt_d = is_last ? 32'd0 : cnt_inc[31:0];
				end
				default: begin
					// drop to zero on a mismatch; the byte is not compared again
					matched_d = sync_hit ? matched_q + 1'b1 : '0;
					hdr_idx_d = '0;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		push           = 1'b0;
		push_word.data = in_byte;
		push_word.id   = id_q;
		push_word.len  = len_q;
		push_word.last = is_last;
		case (phase_q)
			PH_PAYLOAD: push = take;
			default:    push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			matched_q <= '0;
			hdr_idx_q <= '0;
			len_q     <= '0;
			id_q      <= '0;
			cnt_q     <= '0;
			sync_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			matched_q <= matched_d;
			hdr_idx_q <= hdr_idx_d;
			len_q     <= len_d;
			id_q      <= id_d;
			cnt_q     <= cnt_d;
			if (cfg_valid)
				sync_q <= cfg_data;
		end
	end

	a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> len_q != 32'd0)
		else $error("payload phase with zero length");

	a_hdr_idx_only_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEADER |-> hdr_idx_q == '0)
		else $error("header index left nonzero outside header");

	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> cnt_q < len_q)
		else $error("payload count reached length");

	a_push_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (phase_q == PH_PAYLOAD && !qstat.full))
		else $error("push outside payload or into full queue");

endmodule

`default_nettype wire

FILE: hdl/dfr_queue.sv
// Short queue between the front and the output stage.
// Uses dfr_pkg for the word type and depth.
`default_nettype none

module dfr_queue
	import dfr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire dfr_word_t push_word,
	input  wire logic      pop,
	output dfr_word_t      head_word,
	output dfr_qstat_t     qstat
);

	dfr_word_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_word   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_ptr_count_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || qstat.full) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: hdl/dfr_back.sv
// Back part: moves words from the queue into the output register and
// presents them on the master stream. Uses dfr_pkg.
`default_nettype none

module dfr_back
	import dfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dfr_qstat_t qstat,
	input  wire dfr_word_t  head_word,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output dfr_word_t       out_word
);

	logic      valid_q;
	dfr_word_t word_q;

	// refill whenever the register is empty or being drained
	assign pop       = !qstat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk) begin
		if (pop)
			word_q <= head_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(word_q)))
		else $error("output word changed under stall");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!valid_q || out_ready))
		else $error("pop while output register is occupied");

	a_drain_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(!qstat.empty && !valid_q) |=> valid_q)
		else $error("output register idle while queue holds words");

endmodule

`default_nettype wire
